### hdl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared macro wrappers around concurrent properties, clocked on the
// rising edge and disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the controller, datapath and top level of the
// sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// Item operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming item
		logic exec;     // apply the latched item and load the result register
	} cmd_t;

endpackage

`default_nettype wire

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes one item, schedules its execution in the datapath and
// manages the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q;
	logic   out_valid_q;
	logic   res_free;

	// Result register can take a new value when empty or being drained
	assign res_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = (state_q == S_EXEC) && res_free;
	assign out_valid   = out_valid_q;

	// Advance the state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hdl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted cells with a fill count. Every cell compares its priority
// with the latched one in parallel and decides locally whether to keep,
// shift or load, so a push or pop updates all cells together when it executes.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cmd_t                    cmd,
	input  wire logic               opcode,
	input  wire logic        [15:0] priority_req,
	input  wire logic signed [31:0] payload,
	output logic             [1:0]  status,
	output logic signed      [31:0] out_payload,
	output logic             [15:0] out_priority,
	output logic             [4:0]  fill_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// Latched item
	logic        op_q;
	logic [15:0] pr_q;
	logic [31:0] pl_q;

	// Cells and count
	logic [15:0]   prio_q [DEPTH];
	logic [31:0]   pay_q  [DEPTH];
	logic [CW-1:0] count_q;

	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] at_end;
	logic [DEPTH-1:0] prev_ge;

	logic          is_push;
	logic          full;
	logic          empty;
	logic          push_ok;
	logic          pop_ok;
	logic [CW-1:0] count_d;
	logic [CW+4:0] count_ext;

	// Latch the item on acceptance
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			pr_q <= priority_req;
			pl_q <= payload;
		end
	end

	assign is_push = (op_q == OP_PUSH);
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign push_ok = cmd.exec && is_push && !full;
	assign pop_ok  = cmd.exec && !is_push && !empty;
	assign prev_ge = {ge[DEPTH-2:0], 1'b0};

	// Per-cell compare and update
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic        take;
		logic [15:0] src_pr;
		logic [31:0] src_pl;

		assign ge[i]     = (IDX < count_q) && (prio_q[i] >= pr_q);
		assign at_end[i] = (IDX == count_q);
		assign take      = ge[i] || at_end[i];

		// Pop source: the cell behind, the last cell keeps its own
		if (i == DEPTH - 1) begin : g_last
			assign src_pr = prio_q[i];
			assign src_pl = pay_q[i];
		end else begin : g_mid
			assign src_pr = prio_q[i+1];
			assign src_pl = pay_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (push_ok && take) begin
				if (prev_ge[i]) begin
					// Make room: take the entry ahead
					if (i > 0) begin
						prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
						pay_q[i]  <= pay_q[(i > 0) ? i - 1 : 0];
					end
				end else begin
					// Insertion point
					prio_q[i] <= pr_q;
					pay_q[i]  <= pl_q;
				end
			end else if (pop_ok) begin
				prio_q[i] <= src_pr;
				pay_q[i]  <= src_pl;
			end
		end
	end

	// Next fill count
	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (pop_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	assign count_ext = {5'b0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fill_count   <= count_ext[4:0];
			out_payload  <= '0;
			out_priority <= '0;
			if (is_push) begin
				status <= full ? ST_FULL : ST_OK;
			end else if (empty) begin
				status <= ST_EMPTY;
			end else begin
				status       <= ST_OK;
				out_payload  <= signed'(pay_q[0]);
				out_priority <= prio_q[0];
			end
		end
	end

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
// An accepted item is latched; the execute state then loads the result and sets result valid.
// The controller holds one item at a time; its execute state waits only while the result
// register is still full. The next item is accepted while a finished result waits to be taken.
// Reset: arst_n clears the fill count, state machine and result valid;
// cell contents are not reset and are only read below the fill count.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending priority order, smallest at the
// head. Push inserts ahead of equal priorities; pop returns the head.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic        [15:0] priority_req,
	input  wire logic signed [31:0] payload,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [1:0]  status,
	output logic signed      [31:0] out_payload,
	output logic             [15:0] out_priority,
	output logic             [4:0]  fill_count
);

	cmd_t cmd;

	// Sequence items
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// Hold and reorder entries
	spq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.priority_req(priority_req),
		.payload     (payload),
		.status      (status),
		.out_payload (out_payload),
		.out_priority(out_priority),
		.fill_count  (fill_count)
	);

endmodule

`default_nettype wire

### hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel of the sorted priority queue,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] out_payload,
	input wire logic [15:0] out_priority,
	input wire logic [4:0]  fill_count
);

	localparam logic [4:0] FULL_FILL = 5'(DEPTH);

	// Stalled result holds
	`SPQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(fill_count) && $stable(out_payload))

	// Only defined status codes
	`SPQ_ASSERT_SAME(a_code, clk, arst_n, out_valid, status == ST_OK || status == ST_EMPTY || status == ST_FULL)

	// Pop on empty returns zeros and an empty queue
	`SPQ_ASSERT_SAME(a_empty, clk, arst_n, out_valid && status == ST_EMPTY, out_payload == '0 && out_priority == '0 && fill_count == '0)

	// Refused push reports a full queue
	`SPQ_ASSERT_SAME(a_full, clk, arst_n, out_valid && status == ST_FULL, fill_count == FULL_FILL && out_payload == '0)

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_priority_queue
// Sends a short table of push and pop items, then bursts of random items, with
// random gaps and stalls on both channels. The bench keeps its own sorted copy
// of the queue, works out each result from it unless a typed table row gives its own,
// and compares each result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module tb_top;
	import spq_pkg::*;

	localparam int QDEPTH         = 16;
	localparam int N_DIR          = 24;
	localparam int N_RANDOM       = 1330;
	localparam int HOLD_AT        = 250;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	// One result item, fields at the block's widths
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [15:0]        prio;
		logic [4:0]         fill;
	} qresult_t;

	// One row of the directed table; typed rows carry their own result
	typedef struct {
		logic               op;
		logic [15:0]        prio;
		logic signed [31:0] data;
		bit                 typed;
		qresult_t           res;
	} stim_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               opcode       = OP_PUSH;
	logic        [15:0] priority_req = '0;
	logic signed [31:0] payload      = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic        [1:0]  status;
	logic signed [31:0] out_payload;
	logic        [15:0] out_priority;
	logic        [4:0]  fill_count;

	// Expectation carried alongside a directed item
	bit       cur_typed = 1'b0;
	qresult_t cur_exp   = '0;

	// Bench copy of the queue contents
	logic [15:0]        model_prio [QDEPTH];
	logic signed [31:0] model_data [QDEPTH];
	int                 model_count = 0;

	qresult_t  pending_results [$];
	stim_row_t dir_rows [N_DIR];
	qresult_t  acc_res;
	qresult_t  want_res;
	int        n_sent    = 0;
	int        n_results = 0;
	int        n_errors  = 0;
	int        idle_cnt  = 0;

	sorted_priority_queue #(
		.DEPTH(QDEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.priority_req (priority_req),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_payload  (out_payload),
		.out_priority (out_priority),
		.fill_count   (fill_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Apply one item to the bench queue and return the result it causes
	function automatic qresult_t apply_queue_op(input logic op, input logic [15:0] pr,
			input logic signed [31:0] pl);
		qresult_t r;
		int       pos;
		r = '0;
		if (op == OP_PUSH) begin
			if (model_count >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = model_count;
				for (int i = 0; i < model_count; i++) begin
					if (model_prio[i] >= pr) begin
						pos = i;
						break;
					end
				end
				for (int i = model_count; i > pos; i--) begin
					model_prio[i] = model_prio[i - 1];
					model_data[i] = model_data[i - 1];
				end
				model_prio[pos] = pr;
				model_data[pos] = pl;
				model_count++;
				r.status = ST_OK;
			end
		end else begin
			if (model_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_OK;
				r.data   = model_data[0];
				r.prio   = model_prio[0];
				for (int i = 1; i < model_count; i++) begin
					model_prio[i - 1] = model_prio[i];
					model_data[i - 1] = model_data[i];
				end
				model_count--;
			end
		end
		r.fill = 5'(model_count);
		return r;
	endfunction

	// Idle cycles before an item; every fourth stretch runs with no idling
	function automatic int draw_gap(input int n);
		if ((n % 120) < 30)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic op, input logic [15:0] pr,
			input logic signed [31:0] pl, input bit typed, input qresult_t res);
		int gap;
		gap = draw_gap(n_sent);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		priority_req <= pr;
		payload      <= pl;
		cur_typed    <= typed;
		cur_exp      <= res;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Sender: directed table, then random bursts, then drain and verdict
	initial begin : sender
		int          kind;
		int          len;
		int          pmode;
		logic        op;
		logic [15:0] pr;

		dir_rows = '{
			'{OP_POP,  16'hA5A5, 32'sh5A5A5A5A, 1'b1, '{ST_EMPTY, 32'sh0, 16'h0, 5'd0}},
			'{OP_PUSH, 16'hFFFF, 32'sh7FFFFFFF, 1'b1, '{ST_OK, 32'sh0, 16'h0, 5'd1}},
			'{OP_PUSH, 16'h0000, 32'sh80000000, 1'b1, '{ST_OK, 32'sh0, 16'h0, 5'd2}},
			'{OP_PUSH, 16'h8000, 32'shFFFFFFFF, 1'b1, '{ST_OK, 32'sh0, 16'h0, 5'd3}},
			'{OP_PUSH, 16'h8000, 32'sh12345678, 1'b1, '{ST_OK, 32'sh0, 16'h0, 5'd4}},
			'{OP_POP,  16'h5A5A, 32'shA5A5A5A5, 1'b1, '{ST_OK, 32'sh80000000, 16'h0000, 5'd3}},
			// equal priorities: newest comes out first
			'{OP_POP,  16'hFFFF, 32'sh7FFFFFFF, 1'b1, '{ST_OK, 32'sh12345678, 16'h8000, 5'd2}},
			'{OP_PUSH, 16'h0000, 32'sh00000001, 1'b0, '0},
			'{OP_PUSH, 16'h0001, 32'sh00000002, 1'b0, '0},
			'{OP_PUSH, 16'hFFFF, 32'shDEADBEEF, 1'b0, '0},
			'{OP_PUSH, 16'h7FFF, 32'sh00000004, 1'b0, '0},
			'{OP_PUSH, 16'h8000, 32'sh00000005, 1'b0, '0},
			'{OP_PUSH, 16'h0001, 32'shCAFEF00D, 1'b0, '0},
			'{OP_PUSH, 16'hFFFE, 32'sh00000007, 1'b0, '0},
			'{OP_PUSH, 16'h0000, 32'sh80000000, 1'b0, '0},
			'{OP_PUSH, 16'h1234, 32'sh00000009, 1'b0, '0},
			'{OP_PUSH, 16'hFFFF, 32'sh0000000A, 1'b0, '0},
			'{OP_PUSH, 16'h8001, 32'sh0000000B, 1'b0, '0},
			'{OP_PUSH, 16'h00FF, 32'sh0000000C, 1'b0, '0},
			'{OP_PUSH, 16'h0001, 32'sh7FFFFFFF, 1'b0, '0},
			'{OP_PUSH, 16'hABCD, 32'shFFFFFFFF, 1'b0, '0},
			// queue full: item dropped
			'{OP_PUSH, 16'h0000, 32'sh11111111, 1'b1, '{ST_FULL, 32'sh0, 16'h0, 5'd16}},
			'{OP_POP,  16'h0000, 32'sh00000000, 1'b0, '0},
			'{OP_POP,  16'hFFFF, 32'shFFFFFFFF, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].op, dir_rows[i].prio, dir_rows[i].data, dir_rows[i].typed,
				dir_rows[i].res);

		// Random bursts of pushes, pops and mixed items so the queue swings between
		// empty and full; priority ranges vary so ties are frequent
		while (n_sent < N_DIR + N_RANDOM) begin
			kind  = $urandom_range(0, 9);
			len   = $urandom_range(1, 20);
			pmode = $urandom_range(0, 2);
			for (int k = 0; k < len; k++) begin
				if (kind < 4)
					op = OP_PUSH;
				else if (kind < 8)
					op = OP_POP;
				else
					op = 1'($urandom_range(0, 1));
				case (pmode)
					0: pr = 16'($urandom);
					1: pr = 16'($urandom_range(0, 3));
					default: begin
						case ($urandom_range(0, 3))
							0: pr = 16'h0000;
							1: pr = 16'hFFFF;
							2: pr = 16'h7FFF;
							default: pr = 16'h8000;
						endcase
					end
				endcase
				send_item(op, pr, 32'($urandom), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// Drain until every item sent has had its result taken, then give the block
		// time to misbehave
		while (n_results < n_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls per item, one long hold-off to back up the input
	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_gap(n_results);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_results++;
		end
	end

	// Predict on every accepted input item, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				acc_res = apply_queue_op(opcode, priority_req, payload);
				if (cur_typed)
					acc_res = cur_exp;
				pending_results.push_back(acc_res);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result with nothing outstanding, status %h payload %h",
						$time, status, out_payload);
					n_errors++;
				end else begin
					want_res = pending_results.pop_front();
					check_field("status", 32'(want_res.status), 32'(status));
					check_field("out_payload", want_res.data, out_payload);
					check_field("out_priority", 32'(want_res.prio), 32'(out_priority));
					check_field("fill_count", 32'(want_res.fill), 32'(fill_count));
				end
			end
		end
	end

	// Abort when neither channel has moved an item for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
